// ===== rtl/core/lcd4_pkg.sv =====
// lcd4_pkg: types, codes and the microcode program of the character lcd sequencer
// no dependencies
package lcd4_pkg;

    localparam int CMD_W      = 3;
    localparam int PC_W       = 4;
    localparam int PRE_W      = 16;
    localparam int POST_W     = 13;
    localparam int EN_W       = 10;
    localparam int SETTLE_W   = 10;
    localparam int CPU_W      = 8;

    // request kinds
    localparam logic [CMD_W-1:0] CMD_INSTR  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DATA   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INIT   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CURSOR = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

    // register indexes
    localparam logic [1:0] REG_ENABLE_WIDTH = 2'd0;
    localparam logic [1:0] REG_SETTLE       = 2'd1;
    localparam logic [1:0] REG_CLOCKS_US    = 2'd2;

    localparam logic [EN_W-1:0]     RST_ENABLE_WIDTH = 10'd200;
    localparam logic [SETTLE_W-1:0] RST_SETTLE       = 10'd50;
    localparam logic [CPU_W-1:0]    RST_CLOCKS_US    = 8'd16;

    // lcd instruction bytes and wake-up nibbles
    localparam logic [7:0] LCD_HI_MASK    = 8'hF0;
    localparam logic [7:0] LCD_WAKE       = 8'h30;
    localparam logic [7:0] LCD_WAKE_4BIT  = 8'h20;
    localparam logic [7:0] LCD_SET_DDRAM  = 8'h80;
    localparam logic [7:0] LCD_FUNC_SET   = 8'h28;
    localparam logic [7:0] LCD_DISP_ON    = 8'h0C;
    localparam logic [7:0] LCD_ENTRY_MODE = 8'h06;
    localparam logic [7:0] LCD_CLR_DISP   = 8'h01;

    // waits in microseconds
    localparam logic [PRE_W-1:0]  POWER_WAIT_US  = 16'd50000;
    localparam logic [POST_W-1:0] WAKE_FIRST_US  = 13'd5000;
    localparam logic [POST_W-1:0] WAKE_NEXT_US   = 13'd150;
    localparam logic [POST_W-1:0] INIT_CLEAR_US  = 13'd2000;
    localparam logic [POST_W-1:0] CURSOR_US      = 13'd50;
    localparam logic [POST_W-1:0] CLEAR_US       = 13'd5000;

    // nibble source
    localparam logic [1:0] SRC_CONST = 2'd0;
    localparam logic [1:0] SRC_HI    = 2'd1;
    localparam logic [1:0] SRC_LO    = 2'd2;

    // extra post wait
    localparam logic [2:0] EX_NONE        = 3'd0;
    localparam logic [2:0] EX_SETTLE      = 3'd1;
    localparam logic [2:0] EX_SETTLE_REQ  = 3'd2;
    localparam logic [2:0] EX_SETTLE_INIT = 3'd3;
    localparam logic [2:0] EX_WAKE_FIRST  = 3'd4;
    localparam logic [2:0] EX_WAKE_NEXT   = 3'd5;

    // program entry points
    localparam logic [PC_W-1:0] PC_BYTE = 4'd0;
    localparam logic [PC_W-1:0] PC_INIT = 4'd2;

    typedef struct packed {
        logic [1:0] src;
        logic [3:0] nib;
        logic [2:0] extra;
        logic       pre;
        logic       last;
    } ctrl_t;

    typedef struct packed {
        logic  fire;
        ctrl_t ctrl;
    } step_t;

    function automatic ctrl_t ucode_word(input logic [PC_W-1:0] pc);
        ctrl_t w;
        w = '{src: SRC_CONST, nib: 4'h0, extra: EX_NONE, pre: 1'b0, last: 1'b1};
        unique case (pc)
            4'd0:  w = '{SRC_HI,    4'h0,                  EX_NONE,        1'b0, 1'b0};
            4'd1:  w = '{SRC_LO,    4'h0,                  EX_SETTLE_REQ,  1'b0, 1'b1};
            4'd2:  w = '{SRC_CONST, LCD_WAKE[7:4],         EX_WAKE_FIRST,  1'b1, 1'b0};
            4'd3:  w = '{SRC_CONST, LCD_WAKE[7:4],         EX_WAKE_NEXT,   1'b0, 1'b0};
            4'd4:  w = '{SRC_CONST, LCD_WAKE[7:4],         EX_WAKE_NEXT,   1'b0, 1'b0};
            4'd5:  w = '{SRC_CONST, LCD_WAKE_4BIT[7:4],    EX_WAKE_NEXT,   1'b0, 1'b0};
            4'd6:  w = '{SRC_CONST, LCD_FUNC_SET[7:4],     EX_NONE,        1'b0, 1'b0};
            4'd7:  w = '{SRC_CONST, LCD_FUNC_SET[3:0],     EX_SETTLE,      1'b0, 1'b0};
            4'd8:  w = '{SRC_CONST, LCD_DISP_ON[7:4],      EX_NONE,        1'b0, 1'b0};
            4'd9:  w = '{SRC_CONST, LCD_DISP_ON[3:0],      EX_SETTLE,      1'b0, 1'b0};
            4'd10: w = '{SRC_CONST, LCD_CLR_DISP[7:4],     EX_NONE,        1'b0, 1'b0};
            4'd11: w = '{SRC_CONST, LCD_CLR_DISP[3:0],     EX_SETTLE_INIT, 1'b0, 1'b0};
            4'd12: w = '{SRC_CONST, LCD_ENTRY_MODE[7:4],   EX_NONE,        1'b0, 1'b0};
            4'd13: w = '{SRC_CONST, LCD_ENTRY_MODE[3:0],   EX_SETTLE,      1'b0, 1'b1};
            default: w = '{SRC_CONST, 4'h0, EX_NONE, 1'b0, 1'b1};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/core/lcd4_if.sv =====
// lcd4_if: request and nibble channel interfaces
// depends on lcd4_pkg
interface lcd4_req_if;
    logic                        valid;
    logic                        ready;
    logic [lcd4_pkg::CMD_W-1:0]  cmd;
    logic [7:0]                  value;
    logic                        line;
    logic [5:0]                  column;

    modport source (output valid, output cmd, output value, output line, output column,
                    input ready);
    modport sink   (input valid, input cmd, input value, input line, input column,
                    output ready);
endinterface

interface lcd4_nib_if;
    logic                         valid;
    logic                         ready;
    logic                         rs;
    logic [3:0]                   nibble;
    logic [lcd4_pkg::PRE_W-1:0]   pre_wait_us;
    logic [lcd4_pkg::POST_W-1:0]  post_wait_us;
    logic                         last;

    modport source (output valid, output rs, output nibble, output pre_wait_us,
                    output post_wait_us, output last, input ready);
    modport sink   (input valid, input rs, input nibble, input pre_wait_us,
                    input post_wait_us, input last, output ready);
endinterface

// ===== rtl/core/lcd4_seq.sv =====
// lcd4_seq: step counter, dispatch and microcode table
// depends on lcd4_pkg
module lcd4_seq (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    input  logic [lcd4_pkg::CMD_W-1:0]  req_cmd,
    output logic                        req_ready,
    input  logic                        step_ok,
    output lcd4_pkg::step_t             step
);

    logic                         busy_reg, busy_next;
    logic [lcd4_pkg::PC_W-1:0]    pc_reg, pc_next;
    lcd4_pkg::ctrl_t              word;
    logic                         req_take;

    assign word      = lcd4_pkg::ucode_word(pc_reg);
    assign req_ready = !busy_reg;
    assign req_take  = req_valid && !busy_reg;
    assign step.fire = busy_reg && step_ok;
    assign step.ctrl = word;

    always_comb
    begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        if (req_take)
        begin
            unique case (req_cmd)
                lcd4_pkg::CMD_INSTR, lcd4_pkg::CMD_DATA,
                lcd4_pkg::CMD_CURSOR, lcd4_pkg::CMD_CLEAR:
                begin
                    busy_next = 1'b1;
                    pc_next   = lcd4_pkg::PC_BYTE;
                end
                lcd4_pkg::CMD_INIT:
                begin
                    busy_next = 1'b1;
                    pc_next   = lcd4_pkg::PC_INIT;
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase
        end
        else if (step.fire)
        begin
            if (word.last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                pc_next = pc_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pc_reg   <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
        end
    end

endmodule

// ===== rtl/core/lcd4_timer.sv =====
// lcd4_timer: microsecond prescaler and wait counter
// depends on lcd4_pkg
module lcd4_timer (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [lcd4_pkg::PRE_W-1:0]  total_us,
    input  logic [lcd4_pkg::CPU_W-1:0]  clocks_per_us,
    output logic                        done
);

    logic [lcd4_pkg::PRE_W-1:0]  us_reg, us_next;
    logic [lcd4_pkg::CPU_W-1:0]  div_reg, div_next;
    logic [lcd4_pkg::CPU_W-1:0]  reload;

    // zero clocks per microsecond counts as one
    assign reload = (clocks_per_us == '0) ? '0 : clocks_per_us - 1'b1;
    assign done   = (us_reg == '0);

    always_comb
    begin
        us_next  = us_reg;
        div_next = div_reg;
        if (start)
        begin
            us_next  = total_us;
            div_next = reload;
        end
        else if (!done)
        begin
            if (div_reg == '0)
            begin
                div_next = reload;
                us_next  = us_reg - 1'b1;
            end
            else
            begin
                div_next = div_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            us_reg  <= '0;
            div_reg <= '0;
        end
        else
        begin
            us_reg  <= us_next;
            div_reg <= div_next;
        end
    end

endmodule

// ===== rtl/core/lcd4_dp.sv =====
// lcd4_dp: request latch, nibble and wait datapath, output register
// depends on lcd4_pkg, lcd4_timer
module lcd4_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_take,
    input  logic [lcd4_pkg::CMD_W-1:0]    req_cmd,
    input  logic [7:0]                    req_value,
    input  logic                          req_line,
    input  logic [5:0]                    req_column,
    input  lcd4_pkg::step_t               step,
    output logic                          step_ok,
    input  logic [lcd4_pkg::EN_W-1:0]     enable_width_us,
    input  logic [lcd4_pkg::SETTLE_W-1:0] settle_us,
    input  logic [lcd4_pkg::CPU_W-1:0]    clocks_per_us,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          out_rs,
    output logic [3:0]                    out_nibble,
    output logic [lcd4_pkg::PRE_W-1:0]    out_pre,
    output logic [lcd4_pkg::POST_W-1:0]   out_post,
    output logic                          out_last
);

    logic [7:0]                    byte_reg, byte_next;
    logic                          rs_reg, rs_next;
    logic [lcd4_pkg::POST_W-1:0]   req_extra_reg, req_extra_next;
    logic                          valid_reg, valid_next;
    logic                          orsv_reg;
    logic [3:0]                    onib_reg;
    logic [lcd4_pkg::PRE_W-1:0]    opre_reg;
    logic [lcd4_pkg::POST_W-1:0]   opost_reg;
    logic                          olast_reg;
    logic [3:0]                    nib;
    logic [lcd4_pkg::POST_W-1:0]   settle_ext, extra, post;
    logic [lcd4_pkg::PRE_W-1:0]    pre, total;
    logic                          tmr_done;

    always_comb
    begin
        byte_next      = req_value;
        req_extra_next = '0;
        rs_next        = (req_cmd == lcd4_pkg::CMD_DATA);
        unique case (req_cmd)
            lcd4_pkg::CMD_CURSOR:
            begin
                byte_next      = (lcd4_pkg::LCD_SET_DDRAM | {1'b0, req_line, 6'b0})
                                 + {2'b0, req_column};
                req_extra_next = lcd4_pkg::CURSOR_US;
            end
            lcd4_pkg::CMD_CLEAR:
            begin
                byte_next      = lcd4_pkg::LCD_CLR_DISP;
                req_extra_next = lcd4_pkg::CLEAR_US;
            end
            default:
            begin
                byte_next      = req_value;
                req_extra_next = '0;
            end
        endcase
    end

    always_comb
    begin
        unique case (step.ctrl.src)
            lcd4_pkg::SRC_HI: nib = byte_reg[7:4];
            lcd4_pkg::SRC_LO: nib = byte_reg[3:0];
            default:          nib = step.ctrl.nib;
        endcase
    end

    assign settle_ext = {3'b0, settle_us};

    always_comb
    begin
        unique case (step.ctrl.extra)
            lcd4_pkg::EX_SETTLE:      extra = settle_ext;
            lcd4_pkg::EX_SETTLE_REQ:  extra = settle_ext + req_extra_reg;
            lcd4_pkg::EX_SETTLE_INIT: extra = settle_ext + lcd4_pkg::INIT_CLEAR_US;
            lcd4_pkg::EX_WAKE_FIRST:  extra = lcd4_pkg::WAKE_FIRST_US;
            lcd4_pkg::EX_WAKE_NEXT:   extra = lcd4_pkg::WAKE_NEXT_US;
            default:                  extra = '0;
        endcase
    end

    assign post  = {3'b0, enable_width_us} + extra;
    assign pre   = step.ctrl.pre ? lcd4_pkg::POWER_WAIT_US : '0;
    // pre wait, enable high, then enable low plus extra
    assign total = pre + {3'b0, post} + {6'b0, enable_width_us};

    assign step_ok = tmr_done && (!valid_reg || out_ready);

    always_comb
    begin
        valid_next = valid_reg;
        if (step.fire)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            byte_reg      <= byte_next;
            rs_reg        <= rs_next;
            req_extra_reg <= req_extra_next;
        end
        if (step.fire)
        begin
            orsv_reg  <= rs_reg;
            onib_reg  <= nib;
            opre_reg  <= pre;
            opost_reg <= post;
            olast_reg <= step.ctrl.last;
        end
    end

    lcd4_timer u_timer (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (step.fire),
        .total_us      (total),
        .clocks_per_us (clocks_per_us),
        .done          (tmr_done)
    );

    assign out_valid  = valid_reg;
    assign out_rs     = orsv_reg;
    assign out_nibble = onib_reg;
    assign out_pre    = opre_reg;
    assign out_post   = opost_reg;
    assign out_last   = olast_reg;

endmodule

// ===== rtl/core/char_lcd_4bit_write_sequencer.sv =====
// char_lcd_4bit_write_sequencer: top level, apb register file and channel hookup
// depends on lcd4_pkg, lcd4_if, lcd4_seq, lcd4_dp
//
//   channel  dir  transfer
//   req      in   cmd, value, line, column
//   nib      out  rs, nibble, pre_wait_us, post_wait_us, last
//   apb      in   register writes and reads at 0x0, 0x4, 0x8
//
// each nibble loads the wait counter with (pre + enable_width + post) microseconds,
// scaled by clocks_per_us; the next nibble is issued only once that wait runs out
// a byte request gives two nibbles, init gives twelve
// a new request is taken once the last nibble of the previous one is issued
// a stalled nib channel holds the step counter; the wait counter keeps running
// reset clears the step counter, wait counter and output valid; registers
// return to 200, 50 and 16
module char_lcd_4bit_write_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    lcd4_req_if.sink    req,
    lcd4_nib_if.source  nib
);

    logic [lcd4_pkg::EN_W-1:0]     en_reg;
    logic [lcd4_pkg::SETTLE_W-1:0] settle_reg;
    logic [lcd4_pkg::CPU_W-1:0]    cpu_reg;
    logic                          wr;
    logic                          req_ready;
    logic                          step_ok;
    lcd4_pkg::step_t               step;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg     <= lcd4_pkg::RST_ENABLE_WIDTH;
            settle_reg <= lcd4_pkg::RST_SETTLE;
            cpu_reg    <= lcd4_pkg::RST_CLOCKS_US;
        end
        else if (wr)
        begin
            unique case (paddr[3:2])
                lcd4_pkg::REG_ENABLE_WIDTH: en_reg     <= pwdata[lcd4_pkg::EN_W-1:0];
                lcd4_pkg::REG_SETTLE:       settle_reg <= pwdata[lcd4_pkg::SETTLE_W-1:0];
                lcd4_pkg::REG_CLOCKS_US:    cpu_reg    <= pwdata[lcd4_pkg::CPU_W-1:0];
                default:                    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            lcd4_pkg::REG_ENABLE_WIDTH: prdata = {22'b0, en_reg};
            lcd4_pkg::REG_SETTLE:       prdata = {22'b0, settle_reg};
            lcd4_pkg::REG_CLOCKS_US:    prdata = {24'b0, cpu_reg};
            default:                    prdata = '0;
        endcase
    end

    assign req.ready = req_ready;

    lcd4_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_cmd   (req.cmd),
        .req_ready (req_ready),
        .step_ok   (step_ok),
        .step      (step)
    );

    lcd4_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_take        (req.valid && req_ready),
        .req_cmd         (req.cmd),
        .req_value       (req.value),
        .req_line        (req.line),
        .req_column      (req.column),
        .step            (step),
        .step_ok         (step_ok),
        .enable_width_us (en_reg),
        .settle_us       (settle_reg),
        .clocks_per_us   (cpu_reg),
        .out_valid       (nib.valid),
        .out_ready       (nib.ready),
        .out_rs          (nib.rs),
        .out_nibble      (nib.nibble),
        .out_pre         (nib.pre_wait_us),
        .out_post        (nib.post_wait_us),
        .out_last        (nib.last)
    );

endmodule
